// ===== src/dpb_pkg.sv =====
`timescale 1ns / 1ps

package dpb_pkg;

   // pixel geometry
   localparam int COORD_BITS = 12;
   localparam int DEPTH_BITS = 16;

   // register and result widths
   localparam int CFG_W     = 16;
   localparam int OUT_W     = 32;
   localparam int Z_W       = 16;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_AXES  = 2;

   // datapath widths
   localparam int POS_W  = COORD_BITS + 4;
   localparam int DIFF_W = (POS_W > CFG_W) ? POS_W : CFG_W;
   localparam int PROD_W = DIFF_W + DEPTH_BITS;
   localparam int MAG_W  = PROD_W + 4;
   localparam int QX_W   = (MAG_W > OUT_W + 1) ? MAG_W : OUT_W + 1;

   // divider: quotient bits resolved per pipeline stage
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;

   // saturation limits on the quotient magnitude
   localparam logic [QX_W-1:0] SAT_POS_Q = QX_W'(64'h0000_0000_7FFF_FFFF);
   localparam logic [QX_W-1:0] SAT_NEG_Q = QX_W'(64'h0000_0000_8000_0000);

   // register reset values
   localparam logic [CFG_W-1:0] FOCAL_RESET    = 16'd8400;
   localparam logic [CFG_W-1:0] CENTER_X_RESET = 16'd5112;
   localparam logic [CFG_W-1:0] CENTER_Y_RESET = 16'd3832;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCAL_LENGTH = 2'd0,
      CSR_CENTER_X     = 2'd1,
      CSR_CENTER_Y     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] focal_length;
      logic [CFG_W-1:0] center_x;
      logic [CFG_W-1:0] center_y;
   } csr_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][DIFF_W-1:0] diff;
      logic [NUM_AXES-1:0]             neg;
      logic [DEPTH_BITS-1:0]           depth;
      logic                            invalid;
   } front_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][MAG_W-1:0] mag;
      logic [NUM_AXES-1:0]            neg;
      logic [NUM_AXES-1:0]            zero;
      logic [DEPTH_BITS-1:0]          depth;
      logic                           invalid;
   } mag_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][CFG_W-1:0] rem;
      logic [NUM_AXES-1:0][MAG_W-1:0] dq;
      logic [NUM_AXES-1:0]            neg;
      logic [NUM_AXES-1:0]            zero;
      logic [DEPTH_BITS-1:0]          depth;
      logic                           invalid;
   } div_stage_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][MAG_W-1:0] quot;
      logic [NUM_AXES-1:0]            neg;
      logic [NUM_AXES-1:0]            zero;
      logic [DEPTH_BITS-1:0]          depth;
      logic                           invalid;
   } quot_type;

endpackage

// ===== src/depth_pixel_backprojection_top.sv =====
`timescale 1ns / 1ps
// throughput: one transaction per cycle while rsp_stall is low; the restoring divider resolves four quotient bits
// per stage, so the pipeline depth follows the product width
// every stage holds its own valid bit, so a stalled output still lets bubbles fill
// reset clears all valid bits and loads the default focal length and principal point

module depth_pixel_backprojection_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dpb_pkg::COORD_BITS-1:0]       req_pixel_column,
   input  logic [dpb_pkg::COORD_BITS-1:0]       req_pixel_row,
   input  logic [dpb_pkg::DEPTH_BITS-1:0]       req_depth_mm,
   input  logic                                 req_depth_invalid,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [dpb_pkg::OUT_W-1:0]     rsp_point_x,
   output logic signed [dpb_pkg::OUT_W-1:0]     rsp_point_y,
   output logic [dpb_pkg::Z_W-1:0]              rsp_point_z,
   output logic                                 rsp_point_valid,
   input  logic                                 csr_write_enable,
   input  logic [dpb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dpb_pkg::CFG_W-1:0]            csr_write_data
);

   dpb_pkg::csr_type   csr;
   logic               front_ready;
   logic               mag_valid;
   logic               mag_ready;
   dpb_pkg::mag_type   mag;
   logic               quot_valid;
   logic               out_ready;
   dpb_pkg::quot_type  quot;

   logic                                        rsp_valid_ff;
   logic [dpb_pkg::NUM_AXES-1:0][dpb_pkg::OUT_W-1:0] coord_ff;
   logic [dpb_pkg::NUM_AXES-1:0][dpb_pkg::OUT_W-1:0] coord_in;
   logic [dpb_pkg::Z_W-1:0]                     z_ff;
   logic [dpb_pkg::Z_W-1:0]                     z_in;
   logic                                        pv_ff;
   logic                                        pv_in;

   dpb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   dpb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr),
      .in_valid      (req_valid),
      .in_ready      (front_ready),
      .pixel_column  (req_pixel_column),
      .pixel_row     (req_pixel_row),
      .depth_mm      (req_depth_mm),
      .depth_invalid (req_depth_invalid),
      .out_valid     (mag_valid),
      .out_ready     (mag_ready),
      .out_data      (mag)
   );

   dpb_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .divisor   (csr.focal_length),
      .in_valid  (mag_valid),
      .in_ready  (mag_ready),
      .in_data   (mag),
      .out_valid (quot_valid),
      .out_ready (out_ready),
      .out_data  (quot)
   );

   assign req_stall = !front_ready;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   // saturate and restore the sign
   always_comb begin
      logic [dpb_pkg::QX_W-1:0] q;
      logic [dpb_pkg::QX_W-1:0] lim;
      for (int a = 0; a < dpb_pkg::NUM_AXES; a++) begin
         q   = dpb_pkg::QX_W'(quot.quot[a]);
         lim = quot.neg[a] ? dpb_pkg::SAT_NEG_Q : dpb_pkg::SAT_POS_Q;
         if (q > lim) begin
            q = lim;
         end
         if (quot.invalid || quot.zero[a]) begin
            coord_in[a] = '0;
         end else if (quot.neg[a]) begin
            coord_in[a] = dpb_pkg::OUT_W'(0) - q[dpb_pkg::OUT_W-1:0];
         end else begin
            coord_in[a] = q[dpb_pkg::OUT_W-1:0];
         end
      end
      z_in  = quot.invalid ? '0 : dpb_pkg::Z_W'(quot.depth);
      pv_in = !quot.invalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= quot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && quot_valid) begin
         coord_ff <= coord_in;
         z_ff     <= z_in;
         pv_ff    <= pv_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = coord_ff[0];
   assign rsp_point_y     = coord_ff[1];
   assign rsp_point_z     = z_ff;
   assign rsp_point_valid = pv_ff;

endmodule

// ===== src/dpb_csr.sv =====
`timescale 1ns / 1ps

module dpb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [dpb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dpb_pkg::CFG_W-1:0]       csr_write_data,
   output dpb_pkg::csr_type                csr
);

   dpb_pkg::csr_type csr_ff;
   dpb_pkg::csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            dpb_pkg::CSR_FOCAL_LENGTH: csr_in.focal_length = csr_write_data;
            dpb_pkg::CSR_CENTER_X:     csr_in.center_x     = csr_write_data;
            dpb_pkg::CSR_CENTER_Y:     csr_in.center_y     = csr_write_data;
            default:                   csr_in              = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.focal_length <= dpb_pkg::FOCAL_RESET;
         csr_ff.center_x     <= dpb_pkg::CENTER_X_RESET;
         csr_ff.center_y     <= dpb_pkg::CENTER_Y_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ===== src/dpb_front.sv =====
`timescale 1ns / 1ps

module dpb_front (
   input  logic                              clock,
   input  logic                              reset,
   input  dpb_pkg::csr_type                  csr,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [dpb_pkg::COORD_BITS-1:0]    pixel_column,
   input  logic [dpb_pkg::COORD_BITS-1:0]    pixel_row,
   input  logic [dpb_pkg::DEPTH_BITS-1:0]    depth_mm,
   input  logic                              depth_invalid,
   output logic                              out_valid,
   input  logic                              out_ready,
   output dpb_pkg::mag_type                  out_data
);

   logic                 diff_valid_ff;
   dpb_pkg::front_type   diff_ff;
   dpb_pkg::front_type   diff_in;
   logic                 mag_valid_ff;
   dpb_pkg::mag_type     mag_ff;
   dpb_pkg::mag_type     mag_in;
   logic                 mag_ready;
   logic                 diff_ready;

   // first stage: offset from the principal point, as sign and magnitude
   always_comb begin
      logic [dpb_pkg::NUM_AXES-1:0][dpb_pkg::DIFF_W-1:0] pos;
      logic [dpb_pkg::NUM_AXES-1:0][dpb_pkg::DIFF_W-1:0] ctr;
      pos[0] = dpb_pkg::DIFF_W'({pixel_column, 4'b0000});
      pos[1] = dpb_pkg::DIFF_W'({pixel_row, 4'b0000});
      ctr[0] = dpb_pkg::DIFF_W'(csr.center_x);
      ctr[1] = dpb_pkg::DIFF_W'(csr.center_y);
      for (int a = 0; a < dpb_pkg::NUM_AXES; a++) begin
         diff_in.neg[a]  = pos[a] < ctr[a];
         diff_in.diff[a] = diff_in.neg[a] ? (ctr[a] - pos[a]) : (pos[a] - ctr[a]);
      end
      diff_in.depth   = depth_mm;
      diff_in.invalid = depth_invalid;
   end

   // second stage: one multiplier per axis
   always_comb begin
      logic [dpb_pkg::PROD_W-1:0] prod;
      mag_in.neg     = diff_ff.neg;
      mag_in.depth   = diff_ff.depth;
      mag_in.invalid = diff_ff.invalid;
      for (int a = 0; a < dpb_pkg::NUM_AXES; a++) begin
         prod = dpb_pkg::PROD_W'(diff_ff.diff[a]) * dpb_pkg::PROD_W'(diff_ff.depth);
         mag_in.mag[a]  = {prod, 4'b0000};
         mag_in.zero[a] = (prod == '0);
      end
   end

   assign mag_ready  = !mag_valid_ff || out_ready;
   assign diff_ready = !diff_valid_ff || mag_ready;
   assign in_ready   = diff_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
         mag_valid_ff  <= 1'b0;
      end else begin
         if (diff_ready) begin
            diff_valid_ff <= in_valid;
         end
         if (mag_ready) begin
            mag_valid_ff <= diff_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (diff_ready && in_valid) begin
         diff_ff <= diff_in;
      end
      if (mag_ready && diff_valid_ff) begin
         mag_ff <= mag_in;
      end
   end

   assign out_valid = mag_valid_ff;
   assign out_data  = mag_ff;

endmodule

// ===== src/dpb_divider.sv =====
`timescale 1ns / 1ps

module dpb_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dpb_pkg::CFG_W-1:0]     divisor,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  dpb_pkg::mag_type              in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output dpb_pkg::quot_type             out_data
);

   localparam int NS = dpb_pkg::DIV_STAGES;

   // restoring division: remainder on top, dividend shifting out as quotient shifts in
   function automatic dpb_pkg::div_stage_type div_steps(
      input dpb_pkg::div_stage_type s_in,
      input logic [dpb_pkg::CFG_W-1:0] dvs,
      input int first
   );
      dpb_pkg::div_stage_type s;
      logic [dpb_pkg::CFG_W:0] trial;
      s = s_in;
      for (int a = 0; a < dpb_pkg::NUM_AXES; a++) begin
         for (int j = 0; j < dpb_pkg::DIV_STEPS; j++) begin
            if (first + j < dpb_pkg::MAG_W) begin
               trial   = {s.rem[a], s.dq[a][dpb_pkg::MAG_W-1]};
               s.dq[a] = {s.dq[a][dpb_pkg::MAG_W-2:0], 1'b0};
               if (trial >= {1'b0, dvs}) begin
                  trial      = trial - {1'b0, dvs};
                  s.dq[a][0] = 1'b1;
               end
               s.rem[a] = trial[dpb_pkg::CFG_W-1:0];
            end
         end
      end
      return s;
   endfunction

   dpb_pkg::div_stage_type stage_ff [NS];
   dpb_pkg::div_stage_type stage_in [NS];
   dpb_pkg::div_stage_type stage_src [NS];
   logic [NS-1:0]          valid_ff;
   logic [NS-1:0]          valid_src;
   logic [NS:0]            ready;
   dpb_pkg::div_stage_type init;

   always_comb begin
      init.rem     = '0;
      init.dq      = in_data.mag;
      init.neg     = in_data.neg;
      init.zero    = in_data.zero;
      init.depth   = in_data.depth;
      init.invalid = in_data.invalid;
   end

   assign ready[NS] = out_ready;

   for (genvar s = 0; s < NS; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign stage_src[s] = init;
         assign valid_src[s] = in_valid;
      end else begin : g_next
         assign stage_src[s] = stage_ff[s-1];
         assign valid_src[s] = valid_ff[s-1];
      end

      assign stage_in[s] = div_steps(stage_src[s], divisor, s * dpb_pkg::DIV_STEPS);
      assign ready[s]    = !valid_ff[s] || ready[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            valid_ff[s] <= valid_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[s] && valid_src[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign in_ready = ready[0];
   assign out_valid = valid_ff[NS-1];

   always_comb begin
      out_data.quot    = stage_ff[NS-1].dq;
      out_data.neg     = stage_ff[NS-1].neg;
      out_data.zero    = stage_ff[NS-1].zero;
      out_data.depth   = stage_ff[NS-1].depth;
      out_data.invalid = stage_ff[NS-1].invalid;
   end

endmodule

// ===== src/dpb_checker.sv =====
`timescale 1ns / 1ps

module dpb_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [dpb_pkg::OUT_W-1:0]     rsp_point_x,
   input  logic signed [dpb_pkg::OUT_W-1:0]     rsp_point_y,
   input  logic [dpb_pkg::Z_W-1:0]              rsp_point_z,
   input  logic                                 rsp_point_valid
);

   // no transaction survives a reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // invalid depth gives an all-zero point
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |->
         rsp_point_x == 0 && rsp_point_y == 0 && rsp_point_z == 0)
      else $error("invalid point carries non-zero coordinates");

   // zero depth projects onto the origin
   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_valid && rsp_point_z == 0 |->
         rsp_point_x == 0 && rsp_point_y == 0)
      else $error("zero depth gave a non-zero lateral coordinate");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y) &&
         $stable(rsp_point_z) && $stable(rsp_point_valid))
      else $error("stalled result changed");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker (.*);

// ===== tb/sv/backprojection_check.sv =====
`timescale 1ns / 1ps

module backprojection_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [dpb_pkg::COORD_BITS-1:0]       req_pixel_column,
   input  logic [dpb_pkg::COORD_BITS-1:0]       req_pixel_row,
   input  logic [dpb_pkg::DEPTH_BITS-1:0]       req_depth_mm,
   input  logic                                 req_depth_invalid,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [dpb_pkg::OUT_W-1:0]     rsp_point_x,
   input  logic signed [dpb_pkg::OUT_W-1:0]     rsp_point_y,
   input  logic [dpb_pkg::Z_W-1:0]              rsp_point_z,
   input  logic                                 rsp_point_valid,
   input  logic                                 csr_write_enable,
   input  logic [dpb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dpb_pkg::CFG_W-1:0]            csr_write_data,
   output int                                   mismatch_count,
   output int                                   points_in_flight
);
   import dpb_pkg::*;

   localparam logic [63:0] LATERAL_MAX     = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] LATERAL_MIN_MAG = 64'h0000_0000_8000_0000;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic [Z_W-1:0]          z;
      logic                    valid;
   } point_type;

   logic [CFG_W-1:0] focal;
   logic [CFG_W-1:0] centre_x;
   logic [CFG_W-1:0] centre_y;
   point_type        expected_points[$];
   int               mismatches = 0;

   // offset from the principal point scaled by depth over focal length, in 1/16 mm
   function automatic logic [OUT_W-1:0] axis_offset(input logic [COORD_BITS-1:0] coord,
                                                    input logic [CFG_W-1:0] centre,
                                                    input logic [DEPTH_BITS-1:0] depth);
      logic [63:0] pos;
      logic [63:0] diff;
      logic [63:0] mag;
      logic [63:0] quotient;
      logic        below;
      pos   = 64'(coord) << 4;
      below = pos < 64'(centre);
      diff  = below ? 64'(centre) - pos : pos - 64'(centre);
      mag   = diff * 64'(depth) * 64'd16;
      if (mag == 64'd0)
         return '0;
      if (focal == '0) begin
         // no divisor: pin to the limit on the side of the numerator
         quotient = below ? LATERAL_MIN_MAG : LATERAL_MAX;
      end else begin
         quotient = mag / 64'(focal);
         if (below && quotient > LATERAL_MIN_MAG)
            quotient = LATERAL_MIN_MAG;
         else if (!below && quotient > LATERAL_MAX)
            quotient = LATERAL_MAX;
      end
      return below ? OUT_W'(64'd0 - quotient) : quotient[OUT_W-1:0];
   endfunction

   function automatic point_type backproject(input logic [COORD_BITS-1:0] column,
                                             input logic [COORD_BITS-1:0] row,
                                             input logic [DEPTH_BITS-1:0] depth,
                                             input logic invalid);
      point_type point;
      point = '0;
      if (!invalid) begin
         point.x     = axis_offset(column, centre_x, depth);
         point.y     = axis_offset(row, centre_y, depth);
         point.z     = Z_W'(depth);
         point.valid = 1'b1;
      end
      return point;
   endfunction

   task automatic check_field(input string field, input logic signed [OUT_W:0] wanted,
                              input logic signed [OUT_W:0] seen);
      if (seen !== wanted) begin
         $display("%0t: point %s mismatch, expected %0d, actual %0d",
                  $time, field, wanted, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      point_type wanted;
      if (reset) begin
         focal    = FOCAL_RESET;
         centre_x = CENTER_X_RESET;
         centre_y = CENTER_Y_RESET;
         expected_points.delete();
      end else begin
         // results first: a point leaving now belongs to an older transaction
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $display("%0t: point with no transaction waiting, expected none, %s",
                        $time, "actual:");
               $display("   x=%0d y=%0d z=%0d valid=%0b",
                        rsp_point_x, rsp_point_y, rsp_point_z, rsp_point_valid);
               mismatches++;
            end else begin
               wanted = expected_points.pop_front();
               check_field("x", wanted.x, rsp_point_x);
               check_field("y", wanted.y, rsp_point_y);
               check_field("z", wanted.z, rsp_point_z);
               check_field("valid", wanted.valid, rsp_point_valid);
            end
         end
         if (req_valid && !req_stall)
            expected_points.push_back(backproject(req_pixel_column, req_pixel_row,
                                                  req_depth_mm, req_depth_invalid));
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FOCAL_LENGTH: focal    = csr_write_data;
               CSR_CENTER_X:     centre_x = csr_write_data;
               CSR_CENTER_Y:     centre_y = csr_write_data;
               default: ;
            endcase
         end
      end
      mismatch_count   <= mismatches;
      points_in_flight <= expected_points.size();
   end

endmodule

// ===== tb/sv/tb_depth_pixel_backprojection_top.sv =====
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection_top;
   import dpb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_SPARE = 2'd3;
   localparam int PHASES           = 8;
   localparam int STEADY_PHASE     = 5;
   localparam int PIXELS_PER_PHASE = 240;
   localparam int DRAIN_CYCLES     = 24;
   localparam int WATCHDOG_CYCLES  = 2000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [COORD_BITS-1:0]   req_pixel_column;
   logic [COORD_BITS-1:0]   req_pixel_row;
   logic [DEPTH_BITS-1:0]   req_depth_mm;
   logic                    req_depth_invalid;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_point_x;
   logic signed [OUT_W-1:0] rsp_point_y;
   logic [Z_W-1:0]          rsp_point_z;
   logic                    rsp_point_valid;
   logic                    csr_write_enable;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CFG_W-1:0]        csr_write_data;

   int                      mismatch_count;
   int                      points_in_flight;
   int                      quiet_cycles = 0;
   bit                      steady = 1'b0;
   logic [CFG_W-1:0]        centre_x_now;
   logic [CFG_W-1:0]        centre_y_now;

   depth_pixel_backprojection_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_column  (req_pixel_column),
      .req_pixel_row     (req_pixel_row),
      .req_depth_mm      (req_depth_mm),
      .req_depth_invalid (req_depth_invalid),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_point_z       (rsp_point_z),
      .rsp_point_valid   (rsp_point_valid),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   backprojection_check point_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_column  (req_pixel_column),
      .req_pixel_row     (req_pixel_row),
      .req_depth_mm      (req_depth_mm),
      .req_depth_invalid (req_depth_invalid),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_point_z       (rsp_point_z),
      .rsp_point_valid   (rsp_point_valid),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .points_in_flight  (points_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [COORD_BITS-1:0] column, input logic [COORD_BITS-1:0] row,
                             input logic [DEPTH_BITS-1:0] depth, input logic invalid);
      while (!steady && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_pixel_column  <= column;
      req_pixel_row     <= row;
      req_depth_mm      <= depth;
      req_depth_invalid <= invalid;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_pixel();
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] row;
      logic [DEPTH_BITS-1:0] depth;
      int                    pick;
      column = COORD_BITS'($urandom);
      row    = COORD_BITS'($urandom);
      pick   = $urandom_range(9);
      if (pick == 0) begin
         // land on the principal point where it falls on a whole pixel
         column = centre_x_now[CFG_W-1:4];
         row    = centre_y_now[CFG_W-1:4];
      end else if (pick == 1) begin
         column = $urandom_range(1) ? '1 : '0;
         row    = $urandom_range(1) ? '1 : '0;
      end
      pick = $urandom_range(9);
      if (pick < 2)
         depth = DEPTH_BITS'($urandom_range(15));
      else if (pick < 4)
         depth = DEPTH_BITS'(65535 - $urandom_range(15));
      else
         depth = DEPTH_BITS'($urandom);
      send_pixel(column, row, depth, $urandom_range(9) == 0);
   endtask

   task automatic send_corner_pixels();
      send_pixel('0, '0, '0, 1'b0);
      send_pixel('1, '1, '1, 1'b0);
      send_pixel('0, '0, '1, 1'b0);
      send_pixel('1, '0, DEPTH_BITS'(1), 1'b0);
      send_pixel(centre_x_now[CFG_W-1:4], centre_y_now[CFG_W-1:4], DEPTH_BITS'(1000), 1'b0);
      send_pixel('1, '1, '1, 1'b1);
   endtask

   // stop sending and let every outstanding transaction come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (points_in_flight != 0);
   endtask

   task automatic program_intrinsics(input logic [CFG_W-1:0] focal, input logic [CFG_W-1:0] cx,
                                     input logic [CFG_W-1:0] cy);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FOCAL_LENGTH;
      csr_write_data   <= focal;
      @(posedge clock);
      csr_index        <= CSR_CENTER_X;
      csr_write_data   <= cx;
      @(posedge clock);
      csr_index        <= CSR_CENTER_Y;
      csr_write_data   <= cy;
      @(posedge clock);
      // an unmapped index must leave all three registers alone
      csr_index        <= CSR_INDEX_SPARE;
      csr_write_data   <= CFG_W'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      centre_x_now = cx;
      centre_y_now = cy;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_pixel_column  = '0;
      req_pixel_row     = '0;
      req_depth_mm      = '0;
      req_depth_invalid = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_FOCAL_LENGTH;
      csr_write_data    = '0;
      centre_x_now      = CENTER_X_RESET;
      centre_y_now      = CENTER_Y_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_for_drain();
            case (phase)
               1: program_intrinsics(16'd1, 16'd0, 16'hFFFF);
               2: program_intrinsics(16'hFFFF, 16'hFFFF, 16'd0);
               3: program_intrinsics(16'd0, 16'd32768, CFG_W'($urandom));
               4: program_intrinsics(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom),
                                     CFG_W'($urandom));
               7: program_intrinsics(FOCAL_RESET, CENTER_X_RESET, CENTER_Y_RESET);
               default: program_intrinsics(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom),
                                           CFG_W'($urandom));
            endcase
         end
         steady <= (phase == STEADY_PHASE);
         if (phase < 4)
            send_corner_pixels();
         repeat (PIXELS_PER_PHASE) send_random_pixel();
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && points_in_flight == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
